// File: rtl/core/sawft_pkg.sv
`default_nettype none
package sawft_pkg;

    localparam int FRAGMENT_BYTES = 113;
    localparam int PACKET_BYTES   = 2048;

    localparam int ADDR_W  = $clog2(PACKET_BYTES);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int IDX_W   = CNT_W + 1;
    localparam int CHUNK_W = $clog2(FRAGMENT_BYTES + 1);

    // item function codes
    typedef enum logic [1:0] {
        FN_LINK = 2'd0,
        FN_HOST = 2'd1,
        FN_TICK = 2'd2,
        FN_PULL = 2'd3
    } t_func;

    // output kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_LINK = 2'd1;
    localparam logic [1:0] KIND_HOST = 2'd2;

    // frame control types
    localparam logic [1:0] TYPE_FIRST = 2'd0;
    localparam logic [1:0] TYPE_NEXT  = 2'd1;
    localparam logic [1:0] TYPE_ACK   = 2'd2;
    localparam logic [1:0] TYPE_BAD   = 2'd3;

    // status codes
    localparam logic [3:0] ST_NONE      = 4'd0;
    localparam logic [3:0] ST_BAD_TYPE  = 4'd1;
    localparam logic [3:0] ST_NEXT_IDLE = 4'd2;
    localparam logic [3:0] ST_DUP       = 4'd3;
    localparam logic [3:0] ST_ACK_IDLE  = 4'd4;
    localparam logic [3:0] ST_ACK_SEQ   = 4'd5;
    localparam logic [3:0] ST_GARBLED   = 4'd6;
    localparam logic [3:0] ST_GAVE_UP   = 4'd7;
    localparam logic [3:0] ST_RETRY     = 4'd8;
    localparam logic [3:0] ST_REASS_TO  = 4'd9;
    localparam logic [3:0] ST_RECEIVED  = 4'd10;
    localparam logic [3:0] ST_SENT      = 4'd11;
    localparam logic [3:0] ST_BUSY      = 4'd12;
    localparam logic [3:0] ST_HOST_LEN  = 4'd13;
    localparam logic [3:0] ST_ACCEPTED  = 4'd14;

    // configuration register indexes
    localparam logic [1:0] CFG_ACK_WAIT   = 2'd0;
    localparam logic [1:0] CFG_REASS_WAIT = 2'd1;
    localparam logic [1:0] CFG_TRY_LIMIT  = 2'd2;

    typedef struct packed {
        t_func      func;
        logic [7:0] byte_in;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [15:0] ack_wait;
        logic [15:0] reass_wait;
        logic [3:0]  try_limit;
    } t_cfg;

endpackage
`default_nettype wire

// File: rtl/core/sawft_ram.sv
`default_nettype none
module sawft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sawft_front.sv
`default_nettype none
module sawft_front
    import sawft_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_func,
    input  wire logic [7:0] i_byte_in,
    input  wire logic       i_end_of_unit,
    output logic            o_valid,
    output t_item           o_item,
    input  wire logic       i_pop
);

    // two-entry item queue
    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_item      cls;

    always_comb begin
        cls.func    = t_func'(i_func);
        // byte and last only matter for link and host items
        cls.byte_in = (i_func[1] == 1'b0) ? i_byte_in : 8'd0;
        cls.last    = (i_func[1] == 1'b0) ? i_end_of_unit : 1'b0;
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_valid    = (r_cnt != 2'd0);
    assign pop        = i_pop && o_valid;
    assign o_item     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sawft_back.sv
`default_nettype none
module sawft_back
    import sawft_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    input  wire t_item      i_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_out_kind,
    output logic [7:0]      o_byte_out,
    output logic            o_out_last,
    output logic [3:0]      o_status,
    output logic            o_sending,
    output logic            o_receiving
);

    localparam logic [CNT_W-1:0]   PKT   = CNT_W'(PACKET_BYTES);
    localparam logic [CHUNK_W-1:0] FRAG  = CHUNK_W'(FRAGMENT_BYTES);
    localparam logic [IDX_W-1:0]   PKT_I = IDX_W'(PACKET_BYTES);

    localparam logic [1:0] SRC_REG  = 2'd0;
    localparam logic [1:0] SRC_SEND = 2'd1;
    localparam logic [1:0] SRC_RECV = 2'd2;

    logic              r_sa, r_ra, r_sseq, r_rseq;
    logic [CNT_W-1:0]  r_so, r_sr, r_ro, r_rr;
    logic [3:0]        r_tc;
    logic [15:0]       r_at, r_rt;
    logic [7:0]        r_fp, r_ctl, r_flh, r_st3;
    logic [1:0]        r_ap;
    logic [7:0]        r_fop;
    logic [CNT_W-1:0]  r_ho, r_hic;
    logic [15:0]       r_hlf;

    logic              n_sa, n_ra, n_sseq, n_rseq;
    logic [CNT_W-1:0]  n_so, n_sr, n_ro, n_rr;
    logic [3:0]        n_tc;
    logic [15:0]       n_at, n_rt;
    logic [7:0]        n_fp, n_ctl, n_flh, n_st3;
    logic [1:0]        n_ap;
    logic [7:0]        n_fop;
    logic [CNT_W-1:0]  n_ho, n_hic;
    logic [15:0]       n_hlf;

    logic              r_ov, r_olast, r_osa, r_ora;
    logic [1:0]        r_okind, r_osrc;
    logic [7:0]        r_obyte;
    logic [3:0]        r_ost;

    logic [1:0]        kind, src;
    logic [7:0]        obyte;
    logic              olast;
    logic [3:0]        st;

    logic              s_we, s_re, rcv_we, rcv_re;
    logic [ADDR_W-1:0] s_waddr, s_raddr, rcv_waddr, rcv_raddr;
    logic [7:0]        s_rdata, rcv_rdata;

    logic              take;

    assign take  = i_valid && (!r_ov || !i_out_stall);
    assign o_pop = take;

    always_comb begin
        logic [7:0]        fp, ctl, payload;
        logic [1:0]        typ;
        logic              sq, done;
        logic [IDX_W-1:0]  idx;
        logic [15:0]       len;
        logic [CHUNK_W-1:0] chunk;

        n_sa = r_sa; n_ra = r_ra; n_sseq = r_sseq; n_rseq = r_rseq;
        n_so = r_so; n_sr = r_sr; n_ro = r_ro; n_rr = r_rr;
        n_tc = r_tc; n_at = r_at; n_rt = r_rt;
        n_fp = r_fp; n_ctl = r_ctl; n_flh = r_flh; n_st3 = r_st3;
        n_ap = r_ap; n_fop = r_fop; n_ho = r_ho; n_hic = r_hic; n_hlf = r_hlf;
        kind = KIND_NONE; src = SRC_REG; obyte = 8'd0; olast = 1'b0; st = ST_NONE;
        s_we = 1'b0; s_re = 1'b0; rcv_we = 1'b0; rcv_re = 1'b0;
        s_waddr = '0; s_raddr = '0; rcv_waddr = '0; rcv_raddr = '0;
        fp = r_fp; ctl = r_ctl; payload = 8'd0; typ = 2'd0; sq = 1'b0; done = 1'b0;
        idx = '0; len = 16'd0;
        chunk = (r_sr > CNT_W'(FRAG)) ? FRAG : r_sr[CHUNK_W-1:0];

        unique case (i_item.func)
            FN_LINK: begin
                if (fp == 8'd0) begin
                    ctl   = i_item.byte_in;
                    n_ctl = ctl;
                end else if (fp != 8'd255) begin
                    if (fp == 8'd3) begin
                        n_flh = i_item.byte_in;
                    end
                    typ = ctl[1:0];
                    idx = ((typ == TYPE_FIRST) ? '0 : IDX_W'(r_ro)) + IDX_W'(fp) - IDX_W'(1);
                    if (typ[1] == 1'b0 && r_ho == '0 && idx < PKT_I) begin
                        rcv_we    = 1'b1;
                        rcv_waddr = idx[ADDR_W-1:0];
                        if (idx == IDX_W'(3)) begin
                            n_st3 = i_item.byte_in;
                        end
                    end
                end
                if (fp != 8'd255) begin
                    n_fp = fp + 8'd1;
                end
                if (i_item.last) begin
                    n_fp    = 8'd0;
                    payload = fp;
                    typ     = ctl[1:0];
                    sq      = ctl[2];
                    done    = 1'b0;
                    if (typ == TYPE_BAD) begin
                        st = ST_BAD_TYPE;
                    end else if (typ == TYPE_ACK) begin
                        // acknowledgement of our outstanding frame
                        if (!r_sa) begin
                            st = ST_ACK_IDLE;
                        end else if (sq != r_sseq || r_fop != 8'd0) begin
                            st = ST_ACK_SEQ;
                        end else begin
                            n_at = 16'd0;
                            n_so = r_so + CNT_W'(chunk);
                            n_sr = r_sr - CNT_W'(chunk);
                            if (n_sr == '0) begin
                                n_sa = 1'b0;
                                st   = ST_SENT;
                            end else begin
                                n_sseq = ~r_sseq;
                                n_tc   = 4'd0;
                                n_fop  = 8'd1;
                            end
                        end
                    end else if (r_ho != '0) begin
                        st = ST_BUSY;
                    end else begin
                        n_ap = {sq, 1'b1};
                        if (typ == TYPE_FIRST) begin
                            n_ra = 1'b0;
                            n_rt = 16'd0;
                        end else if (!r_ra) begin
                            st   = ST_NEXT_IDLE;
                            done = 1'b1;
                        end else if (sq == r_rseq) begin
                            st   = ST_DUP;
                            done = 1'b1;
                        end
                        if (!done && !n_ra) begin
                            len = {n_flh, n_st3};
                            if (fp < 8'd4 || len > 16'(PACKET_BYTES)) begin
                                st   = ST_GARBLED;
                                done = 1'b1;
                            end else begin
                                n_ra = 1'b1;
                                n_rt = (i_cfg.reass_wait == 16'd0) ? 16'd1 : i_cfg.reass_wait;
                                n_ro = '0;
                                n_rr = len[CNT_W-1:0];
                            end
                        end
                        if (!done) begin
                            if (fp == 8'd255 || n_rr < CNT_W'(payload)) begin
                                n_ra = 1'b0;
                                n_rt = 16'd0;
                                st   = ST_GARBLED;
                            end else begin
                                n_ro   = n_ro + CNT_W'(payload);
                                n_rr   = n_rr - CNT_W'(payload);
                                n_rseq = sq;
                                if (n_rr == '0) begin
                                    n_ho = n_ro;
                                    n_ra = 1'b0;
                                    n_rt = 16'd0;
                                    st   = ST_RECEIVED;
                                end
                            end
                        end
                    end
                end
            end
            FN_HOST: begin
                if (r_sa || r_ra) begin
                    n_hic = '0;
                    n_hlf = 16'd0;
                    st    = ST_BUSY;
                end else begin
                    if (r_hic < PKT) begin
                        s_we    = 1'b1;
                        s_waddr = r_hic[ADDR_W-1:0];
                    end
                    if (r_hic == CNT_W'(2)) begin
                        n_hlf = {i_item.byte_in, r_hlf[7:0]};
                    end
                    if (r_hic == CNT_W'(3)) begin
                        n_hlf = {r_hlf[15:8], i_item.byte_in};
                    end
                    if (r_hic <= PKT) begin
                        n_hic = r_hic + CNT_W'(1);
                    end
                    if (i_item.last) begin
                        len   = n_hlf;
                        n_hic = '0;
                        n_hlf = 16'd0;
                        if ((r_hic + CNT_W'(1)) > PKT
                                || len != 16'(r_hic + CNT_W'(1))) begin
                            st = ST_HOST_LEN;
                        end else begin
                            n_sa   = 1'b1;
                            n_so   = '0;
                            n_sr   = len[CNT_W-1:0];
                            n_sseq = ~r_sseq;
                            n_tc   = 4'd0;
                            n_at   = 16'd0;
                            n_fop  = 8'd1;
                            st     = ST_ACCEPTED;
                        end
                    end
                end
            end
            FN_TICK: begin
                if (r_rt != 16'd0) begin
                    n_rt = r_rt - 16'd1;
                    if (n_rt == 16'd0) begin
                        n_ra = 1'b0;
                        st   = ST_REASS_TO;
                    end
                end
                if (r_at != 16'd0) begin
                    n_at = r_at - 16'd1;
                    if (n_at == 16'd0) begin
                        n_tc = r_tc + 4'd1;
                        if (n_tc == i_cfg.try_limit) begin
                            n_sa = 1'b0;
                            st   = ST_GAVE_UP;
                        end else begin
                            n_fop = 8'd1;
                            st    = ST_RETRY;
                        end
                    end
                end
            end
            FN_PULL: begin
                if (r_ap[0]) begin
                    kind  = KIND_LINK;
                    obyte = {5'd0, r_ap[1], TYPE_ACK};
                    olast = 1'b1;
                    n_ap  = 2'd0;
                end else if (r_fop != 8'd0) begin
                    kind = KIND_LINK;
                    if (r_fop == 8'd1) begin
                        obyte = {5'd0, r_sseq, 1'b0, (r_so != '0)};
                    end else begin
                        idx = IDX_W'(r_so) + IDX_W'(r_fop) - IDX_W'(2);
                        if (idx < PKT_I) begin
                            s_re    = 1'b1;
                            s_raddr = idx[ADDR_W-1:0];
                            src     = SRC_SEND;
                        end
                    end
                    if ((r_fop - 8'd1) >= 8'(chunk)) begin
                        olast = 1'b1;
                        n_fop = 8'd0;
                        n_at  = (i_cfg.ack_wait == 16'd0) ? 16'd1 : i_cfg.ack_wait;
                    end else begin
                        n_fop = r_fop + 8'd1;
                    end
                end else if (r_ho != '0) begin
                    kind = KIND_HOST;
                    idx  = IDX_W'(r_ro) - IDX_W'(r_ho);
                    if (idx < PKT_I) begin
                        rcv_re    = 1'b1;
                        rcv_raddr = idx[ADDR_W-1:0];
                        src       = SRC_RECV;
                    end
                    olast = (r_ho == CNT_W'(1));
                    n_ho  = r_ho - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    sawft_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_send_ram (
        .i_clk   (i_clk),
        .i_we    (take && s_we),
        .i_waddr (s_waddr),
        .i_wdata (i_item.byte_in),
        .i_re    (take && s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    sawft_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_recv_ram (
        .i_clk   (i_clk),
        .i_we    (take && rcv_we),
        .i_waddr (rcv_waddr),
        .i_wdata (i_item.byte_in),
        .i_re    (take && rcv_re),
        .i_raddr (rcv_raddr),
        .o_rdata (rcv_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_okind <= kind;
            r_osrc  <= src;
            r_obyte <= obyte;
            r_olast <= olast;
            r_ost   <= st;
            r_osa   <= n_sa;
            r_ora   <= n_ra;
        end
        if (!i_rst_n) begin
            r_sa <= 1'b0; r_ra <= 1'b0; r_sseq <= 1'b0; r_rseq <= 1'b0;
            r_so <= '0; r_sr <= '0; r_ro <= '0; r_rr <= '0;
            r_tc <= 4'd0; r_at <= 16'd0; r_rt <= 16'd0;
            r_fp <= 8'd0; r_ctl <= 8'd0; r_flh <= 8'd0; r_st3 <= 8'd0;
            r_ap <= 2'd0; r_fop <= 8'd0; r_ho <= '0; r_hic <= '0; r_hlf <= 16'd0;
            r_ov <= 1'b0;
        end else begin
            if (take) begin
                r_sa <= n_sa; r_ra <= n_ra; r_sseq <= n_sseq; r_rseq <= n_rseq;
                r_so <= n_so; r_sr <= n_sr; r_ro <= n_ro; r_rr <= n_rr;
                r_tc <= n_tc; r_at <= n_at; r_rt <= n_rt;
                r_fp <= n_fp; r_ctl <= n_ctl; r_flh <= n_flh; r_st3 <= n_st3;
                r_ap <= n_ap; r_fop <= n_fop; r_ho <= n_ho; r_hic <= n_hic;
                r_hlf <= n_hlf;
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_kind  = r_okind;
    assign o_out_last  = r_olast;
    assign o_status    = r_ost;
    assign o_sending   = r_osa;
    assign o_receiving = r_ora;

    always_comb begin
        case (r_osrc)
            SRC_SEND: o_byte_out = s_rdata;
            SRC_RECV: o_byte_out = rcv_rdata;
            default:  o_byte_out = r_obyte;
        endcase
    end

    a_ack_timer_idle_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_at != 16'd0) |-> (r_fop == 8'd0))
        else $error("ack timer running while a frame is still queued");
    a_reass_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ra |-> (r_rt != 16'd0))
        else $error("reassembly active without timer");
    a_idle_no_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sa |-> (r_at == 16'd0 && r_fop == 8'd0))
        else $error("send idle with frame or timer pending");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |=> (r_ov && $stable(o_byte_out)))
        else $error("stalled result byte changed");

endmodule
`default_nettype wire

// File: rtl/core/stop_and_wait_fragment_tunnel_core.sv
// Stop-and-wait fragmentation tunnel.
// Input channel (i_in_valid / o_in_stall) carries items: link frame bytes,
// host packet bytes, timer ticks and output pulls (i_func). Each item
// gives exactly one result on the output channel (o_out_valid /
// i_out_stall): an outgoing byte for pulls, an event status, and the
// sending / receiving flags after the item.
// Config port (i_cfg_valid / o_cfg_ready, always ready) writes
// ack wait, reassembly wait and try limit; write only while idle.
// Throughput: one item per cycle while the output is not stalled. An
// accepted item passes the two-entry input queue, then the processing
// stage whose output register also holds the packet buffer read data
// for pulls, before its result is valid.
// Reset (synchronous, active low) clears all protocol state and loads the
// register defaults 50 / 200 / 5; the packet buffers need no clearing.
// When the receiver stalls, the result holds, processing halts and the
// input queue fills, after which o_in_stall rises.
`default_nettype none
module stop_and_wait_fragment_tunnel_core
    import sawft_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_byte_in,
    input  wire logic        i_end_of_unit,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_byte_out,
    output logic             o_out_last,
    output logic [3:0]       o_status,
    output logic             o_sending,
    output logic             o_receiving,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_valid, q_pop;
    t_item q_item;

    assign o_cfg_ready = 1'b1;

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_wait   <= 16'd50;
            r_cfg.reass_wait <= 16'd200;
            r_cfg.try_limit  <= 4'd5;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ACK_WAIT:   r_cfg.ack_wait   <= i_cfg_data;
                CFG_REASS_WAIT: r_cfg.reass_wait <= i_cfg_data;
                CFG_TRY_LIMIT:  r_cfg.try_limit  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // front: classify and queue items
    sawft_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_byte_in     (i_byte_in),
        .i_end_of_unit (i_end_of_unit),
        .o_valid       (q_valid),
        .o_item        (q_item),
        .i_pop         (q_pop)
    );

    // back: protocol engine, packet buffers and result register
    sawft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_kind  (o_out_kind),
        .o_byte_out  (o_byte_out),
        .o_out_last  (o_out_last),
        .o_status    (o_status),
        .o_sending   (o_sending),
        .o_receiving (o_receiving)
    );

endmodule
`default_nettype wire
